// File: rtl/xfp_pkg.sv
// Shared types and constants for the XOR frame command parser.
`timescale 1ns / 1ps
package xfp_pkg;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_HDR   = 3'd2;
  localparam logic [2:0] ST_TOO_BIG   = 3'd3;
  localparam logic [2:0] ST_SIZE      = 3'd4;
  localparam logic [2:0] ST_CHECKSUM  = 3'd5;

  localparam int unsigned MIN_FRAME  = 4;
  localparam int unsigned HEAD_BYTES = 3;
  localparam int unsigned LEN_W      = 6;

  localparam logic [7:0] HEADER_RESET = 8'hAA;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] command;
    logic [7:0] length;
  } verdict_t;

endpackage

// File: rtl/xfp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module xfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/xfp_check.sv
// Frame state, header register, payload store writes and the verdict of a buffer.
`timescale 1ns / 1ps
module xfp_check #(
  parameter int MAX_PAYLOAD = 32,
  parameter int AW          = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_data,
  input  logic              in_fire,
  input  logic [7:0]        in_byte,
  input  logic              end_of_buffer,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [7:0]        wr_data,
  output xfp_pkg::verdict_t verdict
);
  import xfp_pkg::*;

  logic [7:0] header_value;
  logic [7:0] byte_count;
  logic [7:0] running_xor;
  logic       header_matched;
  logic [7:0] frame_command;
  logic [7:0] frame_length;

  logic [7:0] count_next;
  logic [7:0] offset;
  logic       ok;

  assign count_next = (byte_count == 8'hFF) ? byte_count : byte_count + 8'd1;
  assign offset     = byte_count - 8'(HEAD_BYTES);

  // Bytes from the fourth on land in the store by offset, if the store has room.
  assign wr_en   = in_fire && (byte_count >= 8'(HEAD_BYTES))
                   && (offset < 8'(MAX_PAYLOAD));
  assign wr_addr = offset[AW-1:0];
  assign wr_data = in_byte;

  always_comb begin
    if (count_next < 8'(MIN_FRAME)) begin
      verdict.status = ST_SHORT;
    end else if (!header_matched) begin
      verdict.status = ST_BAD_HDR;
    end else if (frame_length > 8'(MAX_PAYLOAD)) begin
      verdict.status = ST_TOO_BIG;
    end else if ({1'b0, count_next} != (9'(MIN_FRAME) + {1'b0, frame_length})) begin
      verdict.status = ST_SIZE;
    end else if (running_xor != in_byte) begin
      verdict.status = ST_CHECKSUM;
    end else begin
      verdict.status = ST_OK;
    end
    ok              = (verdict.status == ST_OK);
    verdict.command = ok ? frame_command : 8'd0;
    verdict.length  = ok ? frame_length : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_value   <= HEADER_RESET;
      byte_count     <= 8'd0;
      running_xor    <= 8'd0;
      header_matched <= 1'b0;
      frame_command  <= 8'd0;
      frame_length   <= 8'd0;
    end else begin
      if (cfg_we) begin
        header_value <= cfg_data;
      end
      if (in_fire) begin
        if (end_of_buffer) begin
          byte_count     <= 8'd0;
          running_xor    <= 8'd0;
          header_matched <= 1'b0;
          frame_command  <= 8'd0;
          frame_length   <= 8'd0;
        end else begin
          byte_count  <= count_next;
          running_xor <= running_xor ^ in_byte;
          if (byte_count == 8'd0) begin
            header_matched <= (in_byte == header_value);
          end
          if (byte_count == 8'd1) begin
            frame_command <= in_byte;
          end
          if (byte_count == 8'd2) begin
            frame_length <= in_byte;
          end
        end
      end
    end
  end

endmodule

// File: rtl/xor_frame_command_parser.sv
// The verdict item is presented in the cycle after the final byte's transfer.
// Throughput: one input byte per cycle while a buffer streams in and the results are
// not stalled; on an ok frame the payload items follow, each after a fresh registered
// read of the payload memory, and no input is taken until the last one is loaded.
// Reset: header value returns to 0xAA and the frame state clears; the payload
// memory is not cleared, since an entry is only read after it is written.
`timescale 1ns / 1ps
module xor_frame_command_parser #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       end_of_buffer,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] status,
  output logic [7:0] command,
  output logic [5:0] payload_length,
  output logic [7:0] data_byte,
  output logic       data_valid,
  output logic       last_of_run
);
  import xfp_pkg::*;

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic             state;
  logic [LEN_W-1:0] run_idx;
  logic [LEN_W-1:0] run_len;
  logic             rd_ok;

  logic             in_fire;
  logic             out_free;
  logic             load_payload;
  logic             run_last;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [7:0]       wr_data;
  logic [7:0]       rd_data;
  verdict_t         verdict;
  logic             verdict_ok;

  assign out_free     = !out_valid || out_ready;
  assign in_ready     = (state == S_IDLE) && out_free;
  assign in_fire      = in_valid && in_ready;
  assign verdict_ok   = (verdict.status == ST_OK);
  // The memory is read at run_idx every cycle; rd_ok says the data matches it.
  assign load_payload = (state == S_RUN) && rd_ok && out_free;
  assign run_last     = ((run_idx + 1'b1) == run_len);

  xfp_check #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AW          (AW)
  ) u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .in_fire       (in_fire),
    .in_byte       (in_byte),
    .end_of_buffer (end_of_buffer),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .verdict       (verdict)
  );

  xfp_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (run_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      rd_ok     <= 1'b0;
      run_idx   <= '0;
      run_len   <= '0;
    end else begin
      if (in_fire && end_of_buffer) begin
        out_valid      <= 1'b1;
        status         <= verdict.status;
        command        <= verdict.command;
        payload_length <= verdict.length[LEN_W-1:0];
        data_byte      <= 8'd0;
        data_valid     <= 1'b0;
        last_of_run    <= !verdict_ok || (verdict.length == 8'd0);
        run_idx        <= '0;
        run_len        <= verdict.length[LEN_W-1:0];
        rd_ok          <= 1'b0;
        if (verdict_ok && (verdict.length != 8'd0)) begin
          state <= S_RUN;
        end
      end else if (load_payload) begin
        out_valid   <= 1'b1;
        status      <= ST_OK;
        data_byte   <= rd_data;
        data_valid  <= 1'b1;
        last_of_run <= run_last;
        run_idx     <= run_idx + 1'b1;
        rd_ok       <= 1'b0;
        if (run_last) begin
          state <= S_IDLE;
        end
      end else begin
        if (out_ready) begin
          out_valid <= 1'b0;
        end
        rd_ok <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_verdict_follows: assert property (@(posedge clk) disable iff (rst)
    in_fire && end_of_buffer |=> out_valid && !data_valid)
    else $error("verdict item missing after final byte");

  a_run_index_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> run_idx < run_len)
    else $error("payload read index past frame length");

  a_payload_status_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && data_valid |-> status == ST_OK && command == command)
    else $error("payload item with non-ok status");

  a_run_ends_idle: assert property (@(posedge clk) disable iff (rst)
    load_payload && run_last |=> state == S_IDLE && out_valid && last_of_run)
    else $error("run did not end on its last payload item");

  a_no_input_in_run: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> !in_fire && !wr_en)
    else $error("input taken while payload run is draining");
`endif

endmodule

// File: sim/xfp_frame_checker.sv
// Checker for the XOR frame command parser: predicts results per transfer and compares them.
`timescale 1ns / 1ps
module xfp_frame_checker #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       end_of_buffer,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [2:0] status,
  input  logic [7:0] command,
  input  logic [5:0] payload_length,
  input  logic [7:0] data_byte,
  input  logic       data_valid,
  input  logic       last_of_run,
  output int         mismatches,
  output int         outstanding,
  output int         results_checked,
  output int         ok_frames
);
  import xfp_pkg::*;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] command;
    logic [5:0] length;
    logic [7:0] data;
    logic       data_valid;
    logic       last;
  } frame_result_t;

  frame_result_t expected_results[$];

  logic [7:0] header_reg;
  logic [7:0] bytes_seen;
  logic [7:0] xor_acc;
  logic       header_ok;
  logic [7:0] frame_cmd;
  logic [7:0] frame_len;
  logic [7:0] payload_mem [MAX_PAYLOAD];

  task automatic report(input string what);
    mismatches++;
    $display("error at %0t ns: %s", $realtime, what);
  endtask

  task automatic clear_frame();
    bytes_seen = '0;
    xor_acc    = '0;
    header_ok  = 1'b0;
    frame_cmd  = '0;
    frame_len  = '0;
  endtask

  // Runs the frame state forward by one byte and queues the results it causes.
  task automatic predict_byte(input logic [7:0] b, input logic final_byte);
    int            pos;
    int            frame_size;
    int            len;
    logic [7:0]    xor_prev;
    logic [2:0]    verdict;
    frame_result_t r;
    pos      = int'(bytes_seen);
    xor_prev = xor_acc;
    if (pos == 0) begin
      header_ok = (b == header_reg);
    end else if (pos == 1) begin
      frame_cmd = b;
    end else if (pos == 2) begin
      frame_len = b;
    end else if (pos - int'(HEAD_BYTES) < MAX_PAYLOAD) begin
      payload_mem[pos - int'(HEAD_BYTES)] = b;
    end
    if (bytes_seen != 8'hFF) bytes_seen++;
    xor_acc ^= b;
    if (!final_byte) return;

    frame_size = int'(bytes_seen);
    len        = int'(frame_len);
    if (frame_size < int'(MIN_FRAME)) verdict = ST_SHORT;
    else if (!header_ok) verdict = ST_BAD_HDR;
    else if (len > MAX_PAYLOAD) verdict = ST_TOO_BIG;
    else if (frame_size != int'(MIN_FRAME) + len) verdict = ST_SIZE;
    else if (xor_prev != b) verdict = ST_CHECKSUM;
    else verdict = ST_OK;

    r = '0;
    r.status = verdict;
    if (verdict != ST_OK) begin
      r.last = 1'b1;
      expected_results.push_back(r);
    end else begin
      ok_frames++;
      r.command = frame_cmd;
      r.length  = frame_len[5:0];
      r.last    = (len == 0);
      expected_results.push_back(r);
      for (int i = 0; i < len && i < MAX_PAYLOAD; i++) begin
        r.data       = payload_mem[i];
        r.data_valid = 1'b1;
        r.last       = (i + 1 == len);
        expected_results.push_back(r);
      end
    end
    clear_frame();
  endtask

  task automatic compare_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want)
      report($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  task automatic check_result();
    frame_result_t want;
    results_checked++;
    if (expected_results.size() == 0) begin
      report($sformatf("result with nothing expected (status %0d, data %0h)",
                       status, data_byte));
      return;
    end
    want = expected_results.pop_front();
    compare_field("status", 8'(status), 8'(want.status));
    compare_field("command", command, want.command);
    compare_field("payload_length", 8'(payload_length), 8'(want.length));
    compare_field("data_byte", data_byte, want.data);
    compare_field("data_valid", 8'(data_valid), 8'(want.data_valid));
    compare_field("last_of_run", 8'(last_of_run), 8'(want.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      header_reg = HEADER_RESET;
      clear_frame();
      expected_results.delete();
    end else begin
      // A verdict comes in the cycle after its final byte, so queueing before checking is safe.
      if (in_valid && in_ready) predict_byte(in_byte, end_of_buffer);
      if (cfg_we) header_reg = cfg_data;
      if (out_valid && out_ready) check_result();
    end
    outstanding = expected_results.size();
  end

endmodule

// File: sim/tb_xor_frame_command_parser.sv
// Testbench top for the XOR frame command parser: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_xor_frame_command_parser;
  import xfp_pkg::*;

  localparam int MAX_PAYLOAD  = 32;
  localparam int RANDOM_BYTES = 165;
  localparam int LONG_HOLD    = 120;
  localparam int PHASE_BYTES  = 60;
  localparam int QUIET_BYTES  = 50;

  typedef enum int {
    FRAME_OK,
    FRAME_BAD_SUM,
    FRAME_BAD_HDR,
    FRAME_TOO_BIG,
    FRAME_WRONG_SIZE,
    FRAME_SHORT
  } frame_kind_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       end_of_buffer;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] status;
  logic [7:0] command;
  logic [5:0] payload_length;
  logic [7:0] data_byte;
  logic       data_valid;
  logic       last_of_run;

  int mismatches;
  int outstanding;
  int results_checked;
  int ok_frames;

  int         bytes_sent;
  int         buffers_sent;
  int         header_writes;
  logic [7:0] header_now;
  logic [7:0] frame_bytes[$];
  bit         sender_gaps;
  bit         receiver_gaps;
  bit         hold_request;

  xor_frame_command_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .end_of_buffer (end_of_buffer),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .command       (command),
    .payload_length(payload_length),
    .data_byte     (data_byte),
    .data_valid    (data_valid),
    .last_of_run   (last_of_run)
  );

  xfp_frame_checker #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) checker_i (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .end_of_buffer  (end_of_buffer),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .command        (command),
    .payload_length (payload_length),
    .data_byte      (data_byte),
    .data_valid     (data_valid),
    .last_of_run    (last_of_run),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .results_checked(results_checked),
    .ok_frames      (ok_frames)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("error: run did not finish in time, %0d results still expected", outstanding);
    $display("end of test: mismatches");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold-off when asked for.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (receiver_gaps && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Presents one byte and returns at the falling edge after its transfer.
  // Valid is left high, so the caller either presents the next byte or lowers it.
  task automatic send_byte(input logic [7:0] b, input logic final_byte);
    if (sender_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_byte       <= b;
    end_of_buffer <= final_byte;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    buffers_sent++;
  endtask

  // Appends the XOR of everything so far, which is the frame's checksum byte.
  task automatic seal();
    logic [7:0] sum;
    sum = '0;
    foreach (frame_bytes[i]) sum ^= frame_bytes[i];
    frame_bytes.push_back(sum);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_header(input logic [7:0] value);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we     <= 1'b0;
    header_now = value;
    header_writes++;
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 4);
    if (r < 8) return $urandom_range(0, MAX_PAYLOAD);
    if (r == 8) return MAX_PAYLOAD;
    return 0;
  endfunction

  function automatic frame_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 62) return FRAME_OK;
    if (r < 72) return FRAME_BAD_SUM;
    if (r < 80) return FRAME_BAD_HDR;
    if (r < 86) return FRAME_TOO_BIG;
    if (r < 94) return FRAME_WRONG_SIZE;
    return FRAME_SHORT;
  endfunction

  task automatic build_frame(input frame_kind_t kind, input int len);
    int n_payload;
    frame_bytes.delete();
    if (kind == FRAME_SHORT) begin
      frame_bytes.push_back($urandom_range(0, 1) ? header_now : 8'($urandom));
      repeat ($urandom_range(0, 2)) frame_bytes.push_back(8'($urandom));
      return;
    end
    if (kind == FRAME_BAD_HDR)
      frame_bytes.push_back(header_now ^ 8'($urandom_range(1, 255)));
    else
      frame_bytes.push_back(header_now);
    frame_bytes.push_back(8'($urandom));
    n_payload = len;
    if (kind == FRAME_TOO_BIG) begin
      frame_bytes.push_back(8'($urandom_range(MAX_PAYLOAD + 1, 255)));
      n_payload = $urandom_range(0, 6);
    end else begin
      frame_bytes.push_back(8'(len));
    end
    // A size mismatch either runs long, sometimes past the payload store, or short.
    if (kind == FRAME_WRONG_SIZE) begin
      if (len == 0 || $urandom_range(0, 1)) n_payload = len + $urandom_range(1, 10);
      else n_payload = len - $urandom_range(1, len);
    end
    repeat (n_payload) frame_bytes.push_back(8'($urandom));
    seal();
    if (kind == FRAME_BAD_SUM)
      frame_bytes[frame_bytes.size() - 1] ^= 8'($urandom_range(1, 255));
  endtask

  initial begin
    int          random_start;
    int          phase_start;
    int          next_header;
    bit          hold_done;
    frame_kind_t kind;

    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_byte       = '0;
    end_of_buffer = 1'b0;
    hold_request  = 1'b0;
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
    header_now    = HEADER_RESET;
    next_header   = 0;
    hold_done     = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed frames: every verdict, short twice, then both header extremes.
    frame_bytes = {HEADER_RESET};
    send_frame();
    frame_bytes = {HEADER_RESET, 8'h01, 8'h00};
    send_frame();
    frame_bytes = {8'h55, 8'h12, 8'h00};
    seal();
    send_frame();
    frame_bytes = {HEADER_RESET, 8'h34, 8'h00};
    seal();
    send_frame();
    frame_bytes = {HEADER_RESET, 8'h01, 8'(MAX_PAYLOAD + 1)};
    seal();
    send_frame();
    frame_bytes = {HEADER_RESET, 8'h01, 8'h02};
    seal();
    send_frame();
    frame_bytes = {HEADER_RESET, 8'h01, 8'h00, 8'h00};
    send_frame();
    write_header(8'h00);
    frame_bytes = {8'h00, 8'hFF, 8'h01, 8'hFF};
    seal();
    send_frame();
    write_header(8'hFF);
    frame_bytes = {8'hFF, 8'h00, 8'h00};
    seal();
    send_frame();

    random_start = bytes_sent;
    phase_start  = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      if (bytes_sent - phase_start >= PHASE_BYTES) begin
        case (next_header % 3)
          0: write_header(8'h00);
          1: write_header(8'($urandom));
          default: write_header(8'hFF);
        endcase
        next_header++;
        phase_start = bytes_sent;
      end
      if (!hold_done && bytes_sent - random_start >= PHASE_BYTES / 2) begin
        // Results pile up behind the hold-off until the input stalls.
        hold_request = 1'b1;
        repeat (3) begin
          build_frame(FRAME_OK, $urandom_range(4, 10));
          send_frame();
        end
        wait_drained();
        hold_done = 1'b1;
      end
      if (bytes_sent - random_start >= RANDOM_BYTES - QUIET_BYTES) begin
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
      end
      kind = pick_kind();
      build_frame(kind, pick_length());
      send_frame();
    end

    in_valid <= 1'b0;
    @(negedge clk);
    for (int i = 0; i < 5000 && outstanding != 0; i++) @(negedge clk);
    repeat (10) @(negedge clk);
    if (outstanding != 0)
      $display("error: %0d expected results never arrived", outstanding);
    $display("run covered %0d bytes in %0d buffers, %0d of them accepted frames",
             bytes_sent, buffers_sent, ok_frames);
    $display("%0d results compared across %0d header settings, one %0d-cycle hold-off",
             results_checked, header_writes + 1, LONG_HOLD);
    if (mismatches == 0 && outstanding == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
